[design/rtcc_pkg.sv]
// ----------------------------------------------------------------------------
// rtcc_pkg
// Shared types, constants and calendar helpers for the real-time clock and
// calendar block.
// ----------------------------------------------------------------------------
package rtcc_pkg;

    // Field widths.
    localparam int VAL_W   = 14;
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int CENT_W  = 7;
    localparam int WDAY_W  = 3;
    localparam int H12_W   = 4;
    localparam int SUM_W   = 14;

    // Rollover limits and clamps, at the width of a written value.
    localparam logic [VAL_W-1:0] SEC_MOD   = 14'd60;
    localparam logic [VAL_W-1:0] MIN_MOD   = 14'd60;
    localparam logic [VAL_W-1:0] HOUR_MOD  = 14'd24;
    localparam logic [VAL_W-1:0] DAY_MAX   = 14'd31;
    localparam logic [VAL_W-1:0] MONTH_MAX = 14'd12;
    localparam logic [VAL_W-1:0] YEAR_MIN  = 14'd2000;
    localparam logic [VAL_W-1:0] YEAR_MAX  = 14'd9999;

    // Year split into century and year of century: v / 100 == (v * 5243) >> 19
    // for every v below 43699.
    localparam logic [12:0]       CENT_RECIP = 13'd5243;
    localparam int                CENT_SHIFT = 19;
    localparam logic [VAL_W-1:0]  CENT_SIZE  = 14'd100;
    localparam logic [CENT_W-1:0] LAST_YRC   = 7'd99;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [3:0] WEEK_DAYS = 4'd7;

    // Request codes.
    typedef enum logic [2:0] {
        FN_TICK      = 3'd0,
        FN_SET_SEC   = 3'd1,
        FN_SET_MIN   = 3'd2,
        FN_SET_HOUR  = 3'd3,
        FN_SET_DAY   = 3'd4,
        FN_SET_MONTH = 3'd5,
        FN_SET_YEAR  = 3'd6
    } t_func;

    // Clock and calendar state; the year also kept as century and year of century.
    typedef struct packed {
        logic [SEC_W-1:0]   sec;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [CENT_W-1:0]  cent;
        logic [CENT_W-1:0]  yrc;
    } t_clock;

    localparam t_clock CLOCK_RESET = '{
        sec:    6'd0,
        minute: 6'd0,
        hour:   5'd0,
        day:    5'd1,
        month:  4'd1,
        year:   14'd2000,
        cent:   7'd20,
        yrc:    7'd0
    };

    // One result as seen on the output ports.
    typedef struct packed {
        logic [SEC_W-1:0]   sec;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [WDAY_W-1:0]  wday;
        logic [H12_W-1:0]   hour12;
        logic               pm;
    } t_result;

    // Gregorian leap year from the year of century and the century.
    function automatic logic f_leap(input logic [CENT_W-1:0] cent,
                                    input logic [CENT_W-1:0] yrc);
        logic leap;
        leap = (yrc[1:0] == 2'd0) && ((yrc != 7'd0) || (cent[1:0] == 2'd0));
        return leap;
    endfunction

    // Length of a month; anything that is not a month counts as 31 days.
    function automatic logic [DAY_W-1:0] f_days_in(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        if (month == MONTH_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = 5'd30;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

    // Month term of the weekday sum: 23 * m / 9 plus the constant that goes
    // with the year adjustment (5 for January and February, else 2).
    function automatic logic [5:0] f_wd_offset(input logic [MONTH_W-1:0] month);
        logic [5:0] off;
        case (month)
            4'd1:    off = 6'd7;
            4'd2:    off = 6'd10;
            4'd3:    off = 6'd9;
            4'd4:    off = 6'd12;
            4'd5:    off = 6'd14;
            4'd6:    off = 6'd17;
            4'd7:    off = 6'd19;
            4'd8:    off = 6'd22;
            4'd9:    off = 6'd25;
            4'd10:   off = 6'd27;
            4'd11:   off = 6'd30;
            4'd12:   off = 6'd32;
            default: off = 6'd0;
        endcase
        return off;
    endfunction

    // Hour in 12-hour form, midnight shown as 12.
    function automatic logic [H12_W-1:0] f_hour12(input logic [HOUR_W-1:0] hour);
        logic [H12_W-1:0] h12;
        if (hour == 5'd0) begin
            h12 = 4'd12;
        end else if (hour > 5'd12) begin
            h12 = 4'(hour - 5'd12);
        end else begin
            h12 = hour[H12_W-1:0];
        end
        return h12;
    endfunction

endpackage

[design/rtcc_carry.sv]
// ----------------------------------------------------------------------------
// rtcc_carry
// Input register and clock state. Each request applies its write or tick and
// runs the carry pass into the state register, which is the result handed on.
// ----------------------------------------------------------------------------
module rtcc_carry (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [2:0]                 i_func,
    input  logic [13:0]                i_value,
    input  logic                       i_adv,
    output logic                       o_ready,
    output logic                       o_valid,
    output rtcc_pkg::t_clock           o_clock
);
    import rtcc_pkg::*;

    // Input stage.
    logic                 r_in_vld;
    t_func                r_in_func;
    logic [VAL_W-1:0]     r_in_value;
    logic [YEAR_W-1:0]    r_in_year;
    logic [CENT_W-1:0]    r_in_cent;
    logic [CENT_W-1:0]    r_in_yrc;

    logic                 in_take;
    logic                 st_take;
    logic [VAL_W-1:0]     yr_clamp;
    logic [26:0]          cent_prod;
    logic [CENT_W-1:0]    cent_w;
    logic [VAL_W-1:0]     cent_hund;
    logic [VAL_W-1:0]     yrc_diff;

    // State stage.
    logic                 r_st_vld;
    t_clock               r_st;
    t_clock               n_st;

    logic [VAL_W-1:0]     sec_sum;
    logic [VAL_W-1:0]     min_base;
    logic [VAL_W-1:0]     min_sum;
    logic [VAL_W-1:0]     hour_base;
    logic [VAL_W-1:0]     hour_sum;
    logic                 sec_c;
    logic                 min_c;
    logic                 hour_c;
    logic [DAY_W-1:0]     day_base;
    logic [DAY_W:0]       day_sum;
    logic [MONTH_W-1:0]   month_base;
    logic [YEAR_W-1:0]    year_base;
    logic [CENT_W-1:0]    cent_base;
    logic [CENT_W-1:0]    yrc_base;
    logic [DAY_W-1:0]     dim;
    logic                 roll;
    logic                 year_inc;

    // Handshake: the state takes a request when its result slot is free or leaving.
    assign st_take = r_in_vld && (!r_st_vld || i_adv);
    assign o_ready = !r_in_vld || st_take;
    assign in_take = i_valid && o_ready;
    assign o_valid = r_st_vld;
    assign o_clock = r_st;

    // Clamp a written year and split it into century and year of century.
    always_comb begin
        if (i_value < YEAR_MIN) begin
            yr_clamp = YEAR_MIN;
        end else if (i_value > YEAR_MAX) begin
            yr_clamp = YEAR_MAX;
        end else begin
            yr_clamp = i_value;
        end
        cent_prod = {13'd0, yr_clamp} * {14'd0, CENT_RECIP};
        cent_w    = cent_prod[CENT_SHIFT +: CENT_W];
        cent_hund = {7'd0, cent_w} * CENT_SIZE;
        yrc_diff  = yr_clamp - cent_hund;
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (st_take) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_func  <= t_func'(i_func);
            r_in_value <= i_value;
            r_in_year  <= yr_clamp;
            r_in_cent  <= cent_w;
            r_in_yrc   <= yrc_diff[CENT_W-1:0];
        end
    end

    // Apply the write or tick to the current state.
    always_comb begin
        sec_sum    = {8'd0, r_st.sec};
        min_base   = {8'd0, r_st.minute};
        hour_base  = {9'd0, r_st.hour};
        day_base   = r_st.day;
        month_base = r_st.month;
        year_base  = r_st.year;
        cent_base  = r_st.cent;
        yrc_base   = r_st.yrc;
        case (r_in_func)
            FN_TICK: begin
                sec_sum = {8'd0, r_st.sec} + 14'd1;
            end
            FN_SET_SEC: begin
                sec_sum = r_in_value;
            end
            FN_SET_MIN: begin
                min_base = r_in_value;
            end
            FN_SET_HOUR: begin
                hour_base = r_in_value;
            end
            FN_SET_DAY: begin
                if (r_in_value == 14'd0) begin
                    day_base = 5'd1;
                end else if (r_in_value > DAY_MAX) begin
                    day_base = DAY_MAX[DAY_W-1:0];
                end else begin
                    day_base = r_in_value[DAY_W-1:0];
                end
            end
            FN_SET_MONTH: begin
                if (r_in_value == 14'd0) begin
                    month_base = MONTH_DEC;
                end else if (r_in_value > MONTH_MAX) begin
                    month_base = MONTH_JAN;
                end else begin
                    month_base = r_in_value[MONTH_W-1:0];
                end
            end
            FN_SET_YEAR: begin
                year_base = r_in_year;
                cent_base = r_in_cent;
                yrc_base  = r_in_yrc;
            end
            default: begin
            end
        endcase
    end

    // Carry pass: seconds, minutes, hours, then the day against the month length.
    always_comb begin
        sec_c    = sec_sum >= SEC_MOD;
        min_sum  = min_base + {13'd0, sec_c};
        min_c    = min_sum >= MIN_MOD;
        hour_sum = hour_base + {13'd0, min_c};
        hour_c   = hour_sum >= HOUR_MOD;
        day_sum  = {1'b0, day_base} + {5'd0, hour_c};
        dim      = f_days_in(month_base, f_leap(cent_base, yrc_base));
        roll     = day_sum > {1'b0, dim};
        year_inc = roll && (month_base == MONTH_DEC) && (year_base < YEAR_MAX);

        n_st.sec    = sec_c  ? '0 : sec_sum[SEC_W-1:0];
        n_st.minute = min_c  ? '0 : min_sum[MIN_W-1:0];
        n_st.hour   = hour_c ? '0 : hour_sum[HOUR_W-1:0];
        n_st.day    = roll   ? 5'd1 : day_sum[DAY_W-1:0];
        if (!roll) begin
            n_st.month = month_base;
        end else if (month_base == MONTH_DEC) begin
            n_st.month = MONTH_JAN;
        end else begin
            n_st.month = month_base + 4'd1;
        end

        n_st.year = year_base;
        n_st.cent = cent_base;
        n_st.yrc  = yrc_base;
        if (year_inc) begin
            n_st.year = year_base + 14'd1;
            if (yrc_base == LAST_YRC) begin
                n_st.yrc  = '0;
                n_st.cent = cent_base + 7'd1;
            end else begin
                n_st.yrc  = yrc_base + 7'd1;
            end
        end
    end

    // State register; it also holds the finished result until it moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld <= 1'b0;
            r_st     <= CLOCK_RESET;
        end else begin
            if (st_take) begin
                r_st <= n_st;
            end
            if (st_take) begin
                r_st_vld <= 1'b1;
            end else if (i_adv) begin
                r_st_vld <= 1'b0;
            end
        end
    end

    // The time of day is always rolled over after a request.
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({8'd0, r_st.sec} < SEC_MOD) && ({8'd0, r_st.minute} < MIN_MOD)
        && ({9'd0, r_st.hour} < HOUR_MOD))
        else $error("clock state holds a time of day out of range");

    // The date is always a real calendar date.
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.month >= MONTH_JAN) && (r_st.month <= MONTH_DEC) && (r_st.day != 5'd0)
        && (r_st.day <= f_days_in(r_st.month, f_leap(r_st.cent, r_st.yrc))))
        else $error("clock state holds an invalid date");

    // The century split always agrees with the binary year.
    a_year_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.year == ({7'd0, r_st.cent} * CENT_SIZE + {7'd0, r_st.yrc}))
        else $error("century split does not match the year");

    // The state only moves when a request passes the carry stage.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !st_take |=> $stable(r_st))
        else $error("clock state changed without a request");

endmodule

[design/rtcc_weekday.sv]
// ----------------------------------------------------------------------------
// rtcc_weekday
// Result path: derives the weekday, the 12-hour hour and the pm flag from a
// clock state snapshot over two registered stages.
// ----------------------------------------------------------------------------
module rtcc_weekday (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  rtcc_pkg::t_clock           i_clock,
    input  logic                       i_stall,
    output logic                       o_ready,
    output logic                       o_valid,
    output rtcc_pkg::t_result          o_result
);
    import rtcc_pkg::*;

    logic                 r_s3_vld;
    t_result              r_s3;
    logic [SUM_W-1:0]     r_s3_sum;
    t_result              n_s3;
    logic [SUM_W-1:0]     n_sum;

    logic                 r_out_vld;
    t_result              r_out;
    t_result              n_out;

    logic                 out_rdy;
    logic                 s3_take;
    logic                 in_take;

    logic                 jan_feb;
    logic [YEAR_W-1:0]    y_adj;
    logic [CENT_W-1:0]    c_adj;
    logic [4:0]           fold1;
    logic [3:0]           fold2;
    logic [3:0]           fold3;

    // Pipeline handshake.
    assign out_rdy = !r_out_vld || !i_stall;
    assign s3_take = r_s3_vld && out_rdy;
    assign o_ready = !r_s3_vld || out_rdy;
    assign in_take = i_valid && o_ready;
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // Weekday sum: January and February count as months of the year before.
    always_comb begin
        jan_feb = i_clock.month < MONTH_MAR;
        y_adj   = jan_feb ? (i_clock.year - 14'd1) : i_clock.year;
        c_adj   = (jan_feb && (i_clock.yrc == 7'd0)) ? (i_clock.cent - 7'd1) : i_clock.cent;
        n_sum   = {8'd0, f_wd_offset(i_clock.month)} + {9'd0, i_clock.day} + y_adj
                + {2'd0, y_adj[YEAR_W-1:2]} - {7'd0, c_adj} + {9'd0, c_adj[CENT_W-1:2]};

        n_s3        = '0;
        n_s3.sec    = i_clock.sec;
        n_s3.minute = i_clock.minute;
        n_s3.hour   = i_clock.hour;
        n_s3.day    = i_clock.day;
        n_s3.month  = i_clock.month;
        n_s3.year   = i_clock.year;
        n_s3.hour12 = f_hour12(i_clock.hour);
        n_s3.pm     = i_clock.hour >= 5'd12;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (in_take) begin
            r_s3_vld <= 1'b1;
        end else if (s3_take) begin
            r_s3_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s3     <= n_s3;
            r_s3_sum <= n_sum;
        end
    end

    // Sum modulo 7 by folding octal digits, since 8 is 1 modulo 7.
    always_comb begin
        fold1 = {2'd0, r_s3_sum[2:0]} + {2'd0, r_s3_sum[5:3]} + {2'd0, r_s3_sum[8:6]}
              + {2'd0, r_s3_sum[11:9]} + {3'd0, r_s3_sum[13:12]};
        fold2 = {2'd0, fold1[4:3]} + {1'b0, fold1[2:0]};
        fold3 = {3'd0, fold2[3]} + {1'b0, fold2[2:0]};
        n_out      = r_s3;
        n_out.wday = (fold3 >= WEEK_DAYS) ? 3'(fold3 - WEEK_DAYS) : fold3[WDAY_W-1:0];
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s3_take) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_take) begin
            r_out <= n_out;
        end
    end

endmodule

[design/rtc_calendar_clock.sv]
// ----------------------------------------------------------------------------
// rtc_calendar_clock
// Real-time clock and calendar with Gregorian leap years, years 2000 to 9999.
// ----------------------------------------------------------------------------
// Each request is a one-second tick or a write of one time or date field, and
// each returns one result with the whole clock, the weekday (0 is Sunday), the
// 12-hour hour and a pm flag. The block takes one request per clock cycle
// unless i_stall holds the output and the back-pressure reaches o_stall. The
// write and the full carry pass through seconds, minutes, hours, days, months
// and years finish as the request moves from the input register into the
// clock state registers, and the weekday is worked out in two more registered
// stages before the result shows up on o_valid.
module rtc_calendar_clock (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [13:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_second_now,
    output logic [5:0]  o_minute_now,
    output logic [4:0]  o_hour_now,
    output logic [4:0]  o_day_now,
    output logic [3:0]  o_month_now,
    output logic [13:0] o_year_now,
    output logic [2:0]  o_weekday,
    output logic [3:0]  o_hour_12,
    output logic        o_is_pm
);
    import rtcc_pkg::*;

    logic    in_ready;
    logic    st_valid;
    logic    wd_ready;
    t_clock  st_clock;
    t_result result;

    // Write and carry pass.
    rtcc_carry u_carry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .i_value (i_value),
        .i_adv   (wd_ready),
        .o_ready (in_ready),
        .o_valid (st_valid),
        .o_clock (st_clock)
    );

    // Weekday and 12-hour view.
    rtcc_weekday u_weekday (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (st_valid),
        .i_clock  (st_clock),
        .i_stall  (i_stall),
        .o_ready  (wd_ready),
        .o_valid  (o_valid),
        .o_result (result)
    );

    assign o_stall      = !in_ready;
    assign o_second_now = result.sec;
    assign o_minute_now = result.minute;
    assign o_hour_now   = result.hour;
    assign o_day_now    = result.day;
    assign o_month_now  = result.month;
    assign o_year_now   = result.year;
    assign o_weekday    = result.wday;
    assign o_hour_12    = result.hour12;
    assign o_is_pm      = result.pm;

endmodule
